// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms for the rtl/core modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge, idle during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/slfp_pkg.sv =====
// ----------------------------------------------------------------------------
// slfp_pkg
// types and codes of the sensor link frame parser
// ----------------------------------------------------------------------------
package slfp_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] len_t;
    typedef logic [1:0]  code2_t;
    typedef logic [2:0]  phase_t;

    localparam int AddrWidth = 5;
    typedef logic [AddrWidth-1:0] addr_t;
    typedef logic [31:0]          word_t;
    typedef logic [2:0]           reg_idx_t;

    // parse phases
    localparam phase_t PH_START  = 3'd0;
    localparam phase_t PH_LEN_LO = 3'd1;
    localparam phase_t PH_LEN_HI = 3'd2;
    localparam phase_t PH_CMD    = 3'd3;
    localparam phase_t PH_DATA   = 3'd4;
    localparam phase_t PH_END    = 3'd5;

    // error codes
    localparam code2_t ERR_OK  = 2'd0;
    localparam code2_t ERR_LEN = 2'd1;
    localparam code2_t ERR_CMD = 2'd2;
    localparam code2_t ERR_END = 2'd3;

    // step results
    localparam code2_t RES_PROGRESS = 2'd0;
    localparam code2_t RES_ERROR    = 2'd1;
    localparam code2_t RES_READY    = 2'd2;

    // register indexes
    localparam reg_idx_t REG_START_MARKER  = 3'd0;
    localparam reg_idx_t REG_END_MARKER    = 3'd1;
    localparam reg_idx_t REG_MAX_PAYLOAD   = 3'd2;
    localparam reg_idx_t REG_REQ_SENSOR    = 3'd3;
    localparam reg_idx_t REG_REQ_REBOOT    = 3'd4;
    localparam reg_idx_t REG_REPLY_SENSOR  = 3'd5;
    localparam reg_idx_t REG_REPLY_REBOOT  = 3'd6;

    // register reset values
    localparam byte_t RST_START_MARKER = 8'd170;
    localparam byte_t RST_END_MARKER   = 8'd85;
    localparam len_t  RST_MAX_PAYLOAD  = 16'd64;
    localparam byte_t RST_REQ_SENSOR   = 8'd1;
    localparam byte_t RST_REQ_REBOOT   = 8'd2;
    localparam byte_t RST_REPLY_SENSOR = 8'd129;
    localparam byte_t RST_REPLY_REBOOT = 8'd130;

    // payload lengths demanded by the command classes
    localparam len_t LEN_REQUEST      = 16'd0;
    localparam len_t LEN_REPLY_SENSOR = 16'd2;
    localparam len_t LEN_REPLY_REBOOT = 16'd1;

endpackage

// ===== rtl/core/sensor_link_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// sensor_link_frame_parser_core: byte-wise start/length/command/payload/end parser
// result: registered from each byte transaction, held until the result transaction
// throughput: one byte per cycle while held results are taken, else input stalls
// reset: markers, codes and limit take defaults, parser hunts for start byte
// ----------------------------------------------------------------------------
module sensor_link_frame_parser_core (
    input  logic                clk,
    input  logic                rst_n,
    // byte channel
    input  logic                in_valid,
    output logic                in_ready,
    input  slfp_pkg::byte_t     rx_byte,
    // result channel
    output logic                out_valid,
    input  logic                out_ready,
    output slfp_pkg::code2_t    step_result,
    output slfp_pkg::code2_t    sticky_error,
    output slfp_pkg::byte_t     frame_cmd,
    output slfp_pkg::code2_t    frame_len,
    output slfp_pkg::byte_t     payload_first,
    output slfp_pkg::byte_t     payload_second,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  slfp_pkg::addr_t     paddr,
    input  slfp_pkg::word_t     pwdata,
    output slfp_pkg::word_t     prdata,
    output logic                pready
);
    import slfp_pkg::*;

    `include "assert_macros.svh"

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    byte_t    start_marker_reg;
    byte_t    end_marker_reg;
    len_t     max_payload_reg;
    byte_t    req_sensor_reg;
    byte_t    req_reboot_reg;
    byte_t    reply_sensor_reg;
    byte_t    reply_reboot_reg;

    reg_idx_t cfg_idx;
    logic     cfg_write;

    // word address; the two byte-offset bits are ignored
    assign cfg_idx   = paddr[AddrWidth-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= RST_START_MARKER;
            end_marker_reg   <= RST_END_MARKER;
            max_payload_reg  <= RST_MAX_PAYLOAD;
            req_sensor_reg   <= RST_REQ_SENSOR;
            req_reboot_reg   <= RST_REQ_REBOOT;
            reply_sensor_reg <= RST_REPLY_SENSOR;
            reply_reboot_reg <= RST_REPLY_REBOOT;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_START_MARKER: start_marker_reg <= pwdata[7:0];
                REG_END_MARKER:   end_marker_reg   <= pwdata[7:0];
                REG_MAX_PAYLOAD:  max_payload_reg  <= pwdata[15:0];
                REG_REQ_SENSOR:   req_sensor_reg   <= pwdata[7:0];
                REG_REQ_REBOOT:   req_reboot_reg   <= pwdata[7:0];
                REG_REPLY_SENSOR: reply_sensor_reg <= pwdata[7:0];
                REG_REPLY_REBOOT: reply_reboot_reg <= pwdata[7:0];
                default:          ;  // unmapped word, write dropped
            endcase
        end
    end

    // read mux, zero-extended to the bus width
    always_comb
    begin
        case (cfg_idx)
            REG_START_MARKER: prdata = {24'd0, start_marker_reg};
            REG_END_MARKER:   prdata = {24'd0, end_marker_reg};
            REG_MAX_PAYLOAD:  prdata = {16'd0, max_payload_reg};
            REG_REQ_SENSOR:   prdata = {24'd0, req_sensor_reg};
            REG_REQ_REBOOT:   prdata = {24'd0, req_reboot_reg};
            REG_REPLY_SENSOR: prdata = {24'd0, reply_sensor_reg};
            REG_REPLY_REBOOT: prdata = {24'd0, reply_reboot_reg};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // parser state
    // ------------------------------------------------------------------
    phase_t phase_reg,  phase_next;
    len_t   len_reg,    len_next;
    byte_t  cmd_reg,    cmd_next;
    len_t   count_reg,  count_next;
    byte_t  kept0_reg,  kept0_next;
    byte_t  kept1_reg,  kept1_next;
    code2_t err_reg,    err_next;

    // result register, doubles as the output stage
    logic   out_valid_reg;
    code2_t res_reg,    res_next;
    byte_t  ocmd_reg,   ocmd_next;
    code2_t olen_reg,   olen_next;
    byte_t  op0_reg,    op0_next;
    byte_t  op1_reg,    op1_next;

    logic   in_fire;
    logic   out_fire;

    // a held result only blocks input if nobody takes it this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;

    // ------------------------------------------------------------------
    // command classification against the programmed code set
    // ------------------------------------------------------------------
    function automatic logic code_known(input byte_t c, input byte_t rs, input byte_t rr,
                                        input byte_t ps, input byte_t pr);
        return (c == rs) || (c == rr) || (c == ps) || (c == pr);
    endfunction

    // requests win over the sensor reply, which wins over the reboot reply
    function automatic len_t needed_len(input byte_t c, input byte_t rs, input byte_t rr,
                                        input byte_t ps);
        len_t n;
        if ((c == rs) || (c == rr))
            n = LEN_REQUEST;
        else if (c == ps)
            n = LEN_REPLY_SENSOR;
        else
            n = LEN_REPLY_REBOOT;
        return n;
    endfunction

    logic  byte_known;
    logic  held_known;
    len_t  held_needed;
    len_t  count_inc;

    assign byte_known  = code_known(rx_byte, req_sensor_reg, req_reboot_reg,
                                    reply_sensor_reg, reply_reboot_reg);
    assign held_known  = code_known(cmd_reg, req_sensor_reg, req_reboot_reg,
                                    reply_sensor_reg, reply_reboot_reg);
    assign held_needed = needed_len(cmd_reg, req_sensor_reg, req_reboot_reg,
                                    reply_sensor_reg);
    assign count_inc   = count_reg + 16'd1;

    // ------------------------------------------------------------------
    // one step of the parser per byte transaction
    // ------------------------------------------------------------------
    always_comb
    begin
        logic  do_fail;
        code2_t fail_code;

        phase_next = phase_reg;
        len_next   = len_reg;
        cmd_next   = cmd_reg;
        count_next = count_reg;
        kept0_next = kept0_reg;
        kept1_next = kept1_reg;
        err_next   = err_reg;
        res_next   = RES_PROGRESS;
        ocmd_next  = '0;
        olen_next  = '0;
        op0_next   = '0;
        op1_next   = '0;
        do_fail    = 1'b0;
        fail_code  = ERR_OK;

        case (phase_reg)
            PH_START:
            begin
                // hunt; a matching byte opens a fresh frame
                if (rx_byte == start_marker_reg)
                begin
                    len_next   = '0;
                    cmd_next   = '0;
                    count_next = '0;
                    kept0_next = '0;
                    kept1_next = '0;
                    phase_next = PH_LEN_LO;
                end
            end
            PH_LEN_LO:
            begin
                len_next   = {8'd0, rx_byte};
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                len_next = {rx_byte, len_reg[7:0]};
                if ({rx_byte, len_reg[7:0]} > max_payload_reg)
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_LEN;
                end
                else
                    phase_next = PH_CMD;
            end
            PH_CMD:
            begin
                if (!byte_known)
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_CMD;
                end
                else
                begin
                    cmd_next   = rx_byte;
                    count_next = '0;
                    phase_next = (len_reg == '0) ? PH_END : PH_DATA;
                end
            end
            PH_DATA:
            begin
                // only the first two payload bytes are kept, the rest counted
                if (count_reg == 16'd0)
                    kept0_next = rx_byte;
                if (count_reg == 16'd1)
                    kept1_next = rx_byte;
                count_next = count_inc;
                if (count_inc >= len_reg)
                    phase_next = PH_END;
            end
            PH_END:
            begin
                // closing checks in priority order; registers may have moved
                if (rx_byte != end_marker_reg)
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_END;
                end
                else if (len_reg > max_payload_reg)
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_LEN;
                end
                else if (!held_known)
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_CMD;
                end
                else if (len_reg != held_needed)
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_LEN;
                end
                else
                begin
                    res_next   = RES_READY;
                    ocmd_next  = cmd_reg;
                    olen_next  = len_reg[1:0];
                    op0_next   = kept0_reg;
                    op1_next   = kept1_reg;
                    phase_next = PH_START;
                    len_next   = '0;
                    cmd_next   = '0;
                    count_next = '0;
                    kept0_next = '0;
                    kept1_next = '0;
                    err_next   = ERR_OK;
                end
            end
            default:
            begin
                // unused phase codes: recover with an error but ok status
                do_fail   = 1'b1;
                fail_code = ERR_OK;
            end
        endcase

        // any error drops the frame and goes back to hunting
        if (do_fail)
        begin
            res_next   = RES_ERROR;
            phase_next = PH_START;
            len_next   = '0;
            cmd_next   = '0;
            count_next = '0;
            kept0_next = '0;
            kept1_next = '0;
            err_next   = fail_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            len_reg   <= '0;
            cmd_reg   <= '0;
            count_reg <= '0;
            kept0_reg <= '0;
            kept1_reg <= '0;
            err_reg   <= ERR_OK;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cmd_reg   <= cmd_next;
            count_reg <= count_next;
            kept0_reg <= kept0_next;
            kept1_reg <= kept1_next;
            err_reg   <= err_next;
        end
    end

    // result valid: set by a byte transaction, cleared when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_fire)
            out_valid_reg <= 1'b0;
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_reg  <= res_next;
            ocmd_reg <= ocmd_next;
            olen_reg <= olen_next;
            op0_reg  <= op0_next;
            op1_reg  <= op1_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign step_result    = res_reg;
    assign sticky_error   = err_reg;
    assign frame_cmd      = ocmd_reg;
    assign frame_len      = olen_reg;
    assign payload_first  = op0_reg;
    assign payload_second = op1_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPL(a_ready_clears_error, out_valid_reg && (res_reg == RES_READY),
                 err_reg == ERR_OK, "ready frame with sticky error set")
    `ASSERT_IMPL(a_fields_zero_unless_ready, out_valid_reg && (res_reg != RES_READY),
                 (ocmd_reg == '0) && (olen_reg == '0) && (op0_reg == '0) && (op1_reg == '0),
                 "frame fields nonzero without ready frame")
    `ASSERT_IMPL(a_data_phase_has_length, phase_reg == PH_DATA,
                 len_reg != '0, "payload phase with zero length")
    `ASSERT_NEXT(a_fire_gives_result, in_fire,
                 out_valid_reg, "byte transaction produced no result")

endmodule
